[rtl/ccs_pkg.sv]
`default_nettype none
package ccs_pkg;

   // number of channels tracked in the busy map
   localparam int CHANNELS = 256;
   // channel index and run length widths
   localparam int CH_W  = (CHANNELS > 2) ? $clog2(CHANNELS) : 1;
   localparam int LEN_W = $clog2(CHANNELS + 1);

   // fixed field widths on the ports
   localparam int CHAN_FIELD_W = 8;
   localparam int RUN_FIELD_W  = 9;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 24;

   // request kinds carried on req_tuser
   localparam logic REQ_SAMPLE   = 1'b0;
   localparam logic REQ_EVALUATE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // busy map port controls
   typedef struct packed {
      logic            wr_en;
      logic            wr_busy;
      logic [CH_W-1:0] wr_addr;
      logic [CH_W-1:0] rd_addr;
   } map_ctl_type;

   // run unit controls
   typedef struct packed {
      logic            clear;
      logic            step;
      logic            busy;
      logic [CH_W-1:0] idx;
   } run_ctl_type;

endpackage
`default_nettype wire

[rtl/clear_channel_selector_top.sv]
`default_nettype none
// Clear channel selector. A sample transfer (req_tuser = 0) updates the busy
// mark of one channel: first_burst clears the mark, a busy assessment
// (channel_clear = 0) then sets it; channels at or beyond the channel count
// are ignored. An evaluate transfer (req_tuser = 1) walks the busy map one
// channel per cycle through a single run-length/compare unit and returns one
// result transfer: the middle channel of the first longest run of free
// channels (run end minus half its length) and that length, or channel 0 with
// none_free set when every channel is busy. An evaluation holds req_tready
// low through the map walk, the drain of the registered map read and the
// result load, and longer if the previous result has not been taken yet.
// Samples are still taken while a result waits in the output register. After
// reset the map reads all free; no clearing pass is needed.
module clear_channel_selector_top (
   input  wire                                clock,
   input  wire                                reset,
   // req_tdata: [7:0] channel, [8] first_burst, [9] channel_clear, rest zero
   input  wire  [ccs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: [0] req_type
   input  wire                                req_tuser,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: [7:0] best_channel, [16:8] longest_run, rest zero
   output logic [ccs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: [0] none_free
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready
);
   import ccs_pkg::*;

   state_type state_ff, state_in;
   logic [CH_W-1:0] cnt_ff, cnt_in;
   logic            stg_vld_ff;
   logic [CH_W-1:0] stg_idx_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   map_ctl_type map_ctl;
   run_ctl_type run_ctl;
   logic        rd_busy;
   logic [LEN_W-1:0] best_len;
   logic [CH_W-1:0]  best_end;

   // decoded request fields
   logic [CHAN_FIELD_W-1:0] req_channel;
   logic                    req_first;
   logic                    req_clear;
   logic                    req_fire;
   logic                    in_range;
   logic                    slot_free;
   logic                    load_rsp;
   logic [LEN_W-1:0]        mid_chan;

   assign req_channel = req_tdata[CHAN_FIELD_W-1:0];
   assign req_first   = req_tdata[CHAN_FIELD_W];
   assign req_clear   = req_tdata[CHAN_FIELD_W+1];
   assign req_fire    = req_tvalid & req_tready;
   assign in_range    = {1'b0, req_channel} < (CHAN_FIELD_W+1)'(CHANNELS);
   assign slot_free   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == REQ_EVALUATE)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CH_W'(CHANNELS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready      = 1'b0;
      cnt_in          = cnt_ff;
      load_rsp        = 1'b0;
      map_ctl.wr_en   = 1'b0;
      map_ctl.wr_busy = !req_clear;
      map_ctl.wr_addr = req_channel[CH_W-1:0];
      map_ctl.rd_addr = cnt_ff;
      run_ctl.clear   = 1'b0;
      run_ctl.step    = stg_vld_ff;
      run_ctl.busy    = rd_busy;
      run_ctl.idx     = stg_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_fire && (req_tuser == REQ_EVALUATE)) begin
               run_ctl.clear = 1'b1;
            end
            // a clear sample without first_burst leaves the mark alone
            if (req_fire && (req_tuser == REQ_SAMPLE) && in_range &&
                (req_first || !req_clear)) begin
               map_ctl.wr_en = 1'b1;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CH_W'(1);
         end
         ST_DRAIN: begin
            cnt_in = '0;
         end
         ST_FINISH: begin
            load_rsp = slot_free;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   ccs_map u_map (
      .clock   (clock),
      .reset   (reset),
      .ctl     (map_ctl),
      .rd_busy (rd_busy)
   );

   ccs_run u_run (
      .clock    (clock),
      .reset    (reset),
      .ctl      (run_ctl),
      .best_len (best_len),
      .best_end (best_end)
   );

   // middle of the winning run
   assign mid_chan = LEN_W'(best_end) - (best_len >> 1);

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         if (best_len == '0) begin
            rsp_data_in = '0;
            rsp_user_in = 1'b1;
         end else begin
            rsp_data_in = {(RSP_DATA_W-CHAN_FIELD_W-RUN_FIELD_W)'(0),
                           RUN_FIELD_W'(best_len),
                           CHAN_FIELD_W'(mid_chan)};
            rsp_user_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         stg_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stg_vld_ff   <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_idx_ff  <= cnt_ff;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // none_free results carry all-zero data
   a_none_free_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("none_free result with nonzero data");

   // a found run has a length within the channel count
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         ((rsp_tdata[CHAN_FIELD_W+RUN_FIELD_W-1:CHAN_FIELD_W] != '0) &&
          (rsp_tdata[CHAN_FIELD_W+RUN_FIELD_W-1:CHAN_FIELD_W] <=
           RUN_FIELD_W'(CHANNELS))))
      else $error("longest_run out of range");

   // reported channel lies inside the map
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         ({1'b0, rsp_tdata[CHAN_FIELD_W-1:0]} < (CHAN_FIELD_W+1)'(CHANNELS)))
      else $error("best_channel out of range");

   // an evaluate transfer starts the walk and blocks input
   a_eval_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == REQ_EVALUATE)) |=> !req_tready)
      else $error("input accepted during evaluation");

endmodule
`default_nettype wire

[rtl/ccs_map.sv]
`default_nettype none
module ccs_map (
   input  wire                clock,
   input  wire                reset,
   input  wire ccs_pkg::map_ctl_type ctl,
   output logic               rd_busy
);
   import ccs_pkg::*;

   logic                busy_mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [CHANNELS-1:0] valid_in;
   logic                mem_rd_ff;
   logic                valid_rd_ff;

   // per-entry valid bits stand in for clearing the map at reset
   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         busy_mem[ctl.wr_addr] <= ctl.wr_busy;
      end
      mem_rd_ff   <= busy_mem[ctl.rd_addr];
      valid_rd_ff <= valid_ff[ctl.rd_addr];
   end

   assign rd_busy = mem_rd_ff & valid_rd_ff;

endmodule
`default_nettype wire

[rtl/ccs_run.sv]
`default_nettype none
module ccs_run (
   input  wire                       clock,
   input  wire                       reset,
   input  wire ccs_pkg::run_ctl_type ctl,
   output logic [ccs_pkg::LEN_W-1:0] best_len,
   output logic [ccs_pkg::CH_W-1:0]  best_end
);
   import ccs_pkg::*;

   logic [LEN_W-1:0] run_ff, run_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic [CH_W-1:0]  best_end_ff, best_end_in;
   logic [LEN_W-1:0] run_next;

   // one channel per step: extend or break the current run, keep first maximum
   always_comb begin
      run_next    = ctl.busy ? '0 : run_ff + LEN_W'(1);
      run_in      = run_ff;
      best_len_in = best_len_ff;
      best_end_in = best_end_ff;
      if (ctl.clear) begin
         run_in      = '0;
         best_len_in = '0;
         best_end_in = '0;
      end else if (ctl.step) begin
         run_in = run_next;
         if (run_next > best_len_ff) begin
            best_len_in = run_next;
            best_end_in = ctl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= '0;
         best_len_ff <= '0;
         best_end_ff <= '0;
      end else begin
         run_ff      <= run_in;
         best_len_ff <= best_len_in;
         best_end_ff <= best_end_in;
      end
   end

   assign best_len = best_len_ff;
   assign best_end = best_end_ff;

endmodule
`default_nettype wire

[tb/tb_clear_channel_selector_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_clear_channel_selector_top;
   import ccs_pkg::*;

   // one request transfer: tuser kind and tdata fields (send_req packs them for the wire)
   typedef struct packed {
      logic       kind;
      logic [7:0] channel;
      logic       first_burst;
      logic       channel_clear;
   } chan_req_type;

   // one evaluation result
   typedef struct packed {
      logic [7:0] best_channel;
      logic [8:0] longest_run;
      logic       none_free;
   } scan_result_type;

   // directed row: request plus an optional typed-in result
   typedef struct packed {
      chan_req_type    req;
      logic            typed;
      scan_result_type res;
   } dir_row_type;

   localparam int DIR_ROWS   = 20;
   localparam int PHASE_ITEMS = 350;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = REQ_SAMPLE;
   logic                   req_tvalid = 1'b0;
   wire                    req_tready;
   wire  [RSP_DATA_W-1:0]  rsp_tdata;
   wire                    rsp_tuser;
   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   // local copy of the busy marks, 1 = busy
   bit               busy_marks [0:CHANNELS-1];
   scan_result_type  pending_results [$];
   int               mismatches = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               hold_left = 0;
   int               phase_items;

   clear_channel_selector_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed table. Typed results: whole map free after reset, channel 0
   // busy, both edge channels busy. The rest comes from the predictor.
   // Rows cover first-burst clearing on channel 0, a clear sample that leaves
   // a busy mark alone, ties between equal runs (lowest wins) and an evaluate
   // transfer carrying junk in the ignored fields.
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{'{REQ_EVALUATE, 8'd0,   1'b0, 1'b0}, 1'b1, '{8'd127, 9'd256, 1'b0}},
      '{'{REQ_SAMPLE,   8'd0,   1'b0, 1'b0}, 1'b0, '0},
      '{'{REQ_EVALUATE, 8'd0,   1'b0, 1'b0}, 1'b1, '{8'd128, 9'd255, 1'b0}},
      '{'{REQ_SAMPLE,   8'd255, 1'b0, 1'b0}, 1'b0, '0},
      '{'{REQ_EVALUATE, 8'd0,   1'b0, 1'b0}, 1'b1, '{8'd127, 9'd254, 1'b0}},
      '{'{REQ_SAMPLE,   8'd0,   1'b1, 1'b1}, 1'b0, '0},
      '{'{REQ_EVALUATE, 8'd255, 1'b1, 1'b0}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd128, 1'b1, 1'b0}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd128, 1'b0, 1'b1}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd64,  1'b0, 1'b0}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd192, 1'b0, 1'b0}, 1'b0, '0},
      '{'{REQ_EVALUATE, 8'd0,   1'b0, 1'b0}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd0,   1'b0, 1'b0}, 1'b0, '0},
      '{'{REQ_EVALUATE, 8'd170, 1'b0, 1'b1}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd255, 1'b1, 1'b1}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd64,  1'b1, 1'b1}, 1'b0, '0},
      '{'{REQ_EVALUATE, 8'd85,  1'b1, 1'b1}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd170, 1'b1, 1'b0}, 1'b0, '0},
      '{'{REQ_SAMPLE,   8'd85,  1'b0, 1'b0}, 1'b0, '0},
      '{'{REQ_EVALUATE, 8'd0,   1'b0, 1'b0}, 1'b0, '0}
   };

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // first longest run of free channels, middle channel rounded down
   function automatic scan_result_type best_free_run();
      scan_result_type r;
      int run;
      int best_len;
      int best_end;
      int mid;
      run = 0;
      best_len = 0;
      best_end = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (busy_marks[i]) run = 0;
         else run++;
         if (run > best_len) begin
            best_len = run;
            best_end = i;
         end
      end
      if (best_len == 0) begin
         r = '{8'd0, 9'd0, 1'b1};
      end else begin
         mid = best_end - (best_len >> 1);
         r.best_channel = mid[7:0];
         r.longest_run  = best_len[8:0];
         r.none_free    = 1'b0;
      end
      return r;
   endfunction

   // Offer one transfer, hold it until taken, then fold it into the model.
   task automatic send_req(input chan_req_type rq, input logic typed,
                           input scan_result_type typed_res);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = rq.kind;
      req_tdata  = {{(REQ_DATA_W-10){1'b0}}, rq.channel_clear, rq.first_burst, rq.channel};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (rq.kind == REQ_EVALUATE) begin
         pending_results.push_back(typed ? typed_res : best_free_run());
      end else if (int'(rq.channel) < CHANNELS) begin
         if (rq.first_burst) busy_marks[rq.channel] = 1'b0;
         if (!rq.channel_clear) busy_marks[rq.channel] = 1'b1;
      end
      phase_items++;
   endtask

   task automatic send_sample(input int ch, input logic first, input logic clr);
      send_req('{REQ_SAMPLE, ch[7:0], first, clr}, 1'b0, '0);
   endtask

   task automatic send_evaluate();
      send_req('{REQ_EVALUATE, 8'($urandom), 1'($urandom), 1'($urandom)}, 1'b0, '0);
   endtask

   // a contiguous stretch of channels, marked busy or cleared
   task automatic mark_window(input int base, input int len, input logic make_busy);
      for (int i = 0; i < len; i++) begin
         if (make_busy) send_sample((base + i) % CHANNELS, 1'($urandom), 1'b0);
         else send_sample((base + i) % CHANNELS, 1'b1, 1'b1);
      end
   endtask

   // stop offering, then wait for every expected result
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver: a long hold-off when asked for, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Result checker: every result transfer against the oldest expectation.
   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing pending", rsp_tdata, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[7:0] !== want.best_channel)
               report_mismatch("best_channel", rsp_tdata[7:0], want.best_channel);
            if (rsp_tdata[16:8] !== want.longest_run)
               report_mismatch("longest_run", rsp_tdata[16:8], want.longest_run);
            if (rsp_tuser !== want.none_free)
               report_mismatch("none_free", rsp_tuser, want.none_free);
            if (rsp_tdata[RSP_DATA_W-1:17] !== '0)
               report_mismatch("rsp_tdata padding", rsp_tdata[RSP_DATA_W-1:17], 0);
         end
      end
   end

   initial begin
      int r;
      int free_pct;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      phase_items = 0;
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
      end
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  free_pct = 75; end
            1: begin send_idle_pct = 58; rsp_stall_pct = 0;  free_pct = 35; end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 58; free_pct = 60; end
            default: begin send_idle_pct = 26; rsp_stall_pct = 26; free_pct = 80; end
         endcase
         phase_items = 0;

         if (phase == 0) begin
            // receiver holds off while evaluations and samples keep coming:
            // the output register fills and the next evaluate stalls req_tready
            hold_left = 900;
            for (int k = 0; k < 3; k++) begin
               send_evaluate();
               repeat (20) send_sample($urandom_range(CHANNELS - 1), 1'($urandom), 1'($urandom));
            end
            send_evaluate();
            // sender pauses until every result is back
            wait_drained();
         end
         if (phase == 1) begin
            // whole map busy, then nothing free to report
            mark_window(0, CHANNELS, 1'b1);
            send_evaluate();
         end

         while (phase_items < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 8) begin
               send_evaluate();
            end else if (r < 14) begin
               mark_window($urandom_range(CHANNELS - 1), $urandom_range(1, 24), 1'($urandom));
            end else begin
               send_sample($urandom_range(CHANNELS - 1), 1'($urandom),
                           $urandom_range(99) < free_pct);
            end
         end
         @(negedge clock);
         req_tvalid = 1'b0;
         wait_drained();
      end

      // tail: catch any stray result transfer
      repeat (CHANNELS + 16) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", pending_results.size(), 0);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
